// File: hdl/ped_pkg.sv
// ped_pkg: shared widths, types, state codes and constant tables for the
// prime exponent distance block (smallest-factor sieve and factor stepper).
// No dependencies.
package ped_pkg;

	localparam int VALUE_LIMIT = 65536;
	localparam int VAL_W       = $clog2(VALUE_LIMIT);
	localparam int PROD_W      = 2 * VAL_W;
	localparam int IN_W        = 16;
	localparam int CNT_W       = 3;
	localparam int DIST_W      = 5;
	localparam int DIFF_W      = $clog2(VAL_W + 1) + 1;
	localparam int ACC_W       = $clog2(2 * VAL_W + 1) + 1;

	function automatic int root_ceil(input int lim);
		int s;
		s = 0;
		while (s * s < lim) begin
			s = s + 1;
		end
		return s;
	endfunction

	localparam int ROOT_CNT = root_ceil(VALUE_LIMIT);
	localparam int SPF_W    = $clog2(ROOT_CNT);
	localparam int TAB_N    = 2 ** SPF_W;

	typedef logic [VAL_W-1:0]         val_t;
	typedef logic [VAL_W:0]           ext_t;
	typedef logic [PROD_W-1:0]        prod_t;
	typedef logic [SPF_W-1:0]         spf_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic [DIFF_W-1:0]        mag_t;
	typedef logic [ACC_W-1:0]         acc_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [DIST_W-1:0]        dist_t;
	typedef logic [TAB_N-1:0]         prime_mask_t;
	typedef val_t                     recip_tab_t [TAB_N];

	localparam ext_t P_NONE   = ext_t'(2 ** VAL_W);
	localparam acc_t DIST_MAX = acc_t'(2 ** DIST_W - 1);

	typedef enum logic [3:0] {
		ST_INIT,
		ST_SV_NEXT,
		ST_SV_SQ,
		ST_SV_MARK,
		ST_IDLE,
		ST_LD_A,
		ST_LD_B,
		ST_LD_WAIT,
		ST_STEP,
		ST_MUL,
		ST_RD,
		ST_RD_WAIT,
		ST_FIN
	} ped_state_t;

	function automatic prime_mask_t build_prime_mask();
		prime_mask_t m;
		m    = '1;
		m[0] = 1'b0;
		m[1] = 1'b0;
		for (int i = 2; i < TAB_N; i++) begin
			if (m[i]) begin
				for (int k = i * i; k < TAB_N; k = k + i) begin
					m[k] = 1'b0;
				end
			end
		end
		return m;
	endfunction

	// ceil(2^VAL_W / p) by shift and subtract; exact quotient for any multiple of p
	function automatic recip_tab_t build_recip();
		recip_tab_t t;
		longint     num;
		longint     rem_l;
		val_t       quo;
		for (int p = 0; p < TAB_N; p++) begin
			t[p] = '0;
			if (p >= 2) begin
				num   = (longint'(1) << VAL_W) + longint'(p) - 1;
				rem_l = 0;
				quo   = '0;
				for (int i = VAL_W; i >= 0; i--) begin
					rem_l = (rem_l << 1) | ((num >> i) & 1);
					if (rem_l >= longint'(p)) begin
						rem_l = rem_l - longint'(p);
						if (i < VAL_W) begin
							quo[i] = 1'b1;
						end
					end
				end
				t[p] = quo;
			end
		end
		return t;
	endfunction

	localparam prime_mask_t PRIME_MASK = build_prime_mask();
	localparam recip_tab_t  RECIP      = build_recip();

endpackage

// File: hdl/ped_req_if.sv
// ped_req_if: request channel carrying the two values to compare.
// Depends on ped_pkg for field widths.
interface ped_req_if;
	logic                      valid;
	logic                      ready;
	logic [ped_pkg::IN_W-1:0]  first_value;
	logic [ped_pkg::IN_W-1:0]  second_value;

	modport source (output valid, output first_value, output second_value, input ready);
	modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

// File: hdl/ped_rsp_if.sv
// ped_rsp_if: result channel with prime count, exponent distance and error flag.
// Depends on ped_pkg for field widths.
interface ped_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [ped_pkg::CNT_W-1:0]   distinct_primes_first;
	logic [ped_pkg::DIST_W-1:0]  exponent_distance;
	logic                        input_error;

	modport source (output valid, output distinct_primes_first, output exponent_distance,
		output input_error, input ready);
	modport sink   (input valid, input distinct_primes_first, input exponent_distance,
		input input_error, output ready);
endinterface

// File: hdl/prime_exponent_distance.sv
// prime_exponent_distance: top level with smallest-factor table, sieve and factor stepper.
// Depends on ped_pkg, ped_req_if and ped_rsp_if.
//
// After reset the block clears its smallest-factor table and then sieves it, one
// table write per cycle for every multiple p*p, p*p+p, ... of each prime p below
// sqrt(VALUE_LIMIT); req.ready stays low until then. A request then takes one factor
// step for each prime factor of both values, counted with multiplicity; a rejected
// request goes straight to the result. Each factor step is a table read on the
// single read port, a wait for the registered data, and an exact division by the
// smallest factor done as one multiply by a constant reciprocal on the shared
// multiplier (or a quotient of one when the value is prime), which also squares the
// primes during the sieve. The result sits in an output register, so the next
// request is taken while it waits to be read.
module prime_exponent_distance (
	input  logic      clk,
	input  logic      arst_n,
	ped_req_if.sink   req,
	ped_rsp_if.source rsp
);

	ped_pkg::ped_state_t state_q, state_d;

	ped_pkg::spf_t mem [ped_pkg::VALUE_LIMIT];
	logic          mem_we;
	ped_pkg::val_t mem_waddr;
	ped_pkg::val_t mem_raddr;
	ped_pkg::spf_t mem_wdata;
	ped_pkg::spf_t rd_q;

	ped_pkg::ext_t  cnt_q;
	ped_pkg::spf_t  pi_q;
	ped_pkg::ext_t  j_next;

	ped_pkg::val_t  a_q, b_q;
	ped_pkg::spf_t  raw_a_q, raw_b_q;
	logic           err_q;
	ped_pkg::val_t  mul_a_q, mul_b_q;
	ped_pkg::prod_t product;
	logic           side_q;
	logic           prime_q;
	ped_pkg::val_t  quot;

	ped_pkg::diff_t diff_q;
	ped_pkg::mag_t  mag;
	ped_pkg::acc_t  dist_q;
	ped_pkg::acc_t  dist_tot;
	ped_pkg::cnt_t  cnt_a_q;
	ped_pkg::val_t  cur_q;
	ped_pkg::val_t  last_a_q;

	ped_pkg::ext_t  pa_eff, pb_eff, p_sel;
	ped_pkg::spf_t  raw_sel;
	logic           take_a;
	logic           both_done;
	logic           accept;
	logic           accept_err;
	logic           load_rsp;

	logic           rsp_vld_q;
	ped_pkg::cnt_t  out_cnt_q;
	ped_pkg::dist_t out_dist_q;
	logic           out_err_q;

	assign accept     = req.valid && req.ready;
	assign accept_err = (req.first_value == '0) || (req.second_value == '0) ||
		(32'(req.first_value) >= ped_pkg::VALUE_LIMIT) ||
		(32'(req.second_value) >= ped_pkg::VALUE_LIMIT);

	assign product = ped_pkg::prod_t'(mul_a_q) * ped_pkg::prod_t'(mul_b_q);
	assign quot    = prime_q ? ped_pkg::val_t'(1) : product[ped_pkg::PROD_W-1:ped_pkg::VAL_W];
	assign j_next  = cnt_q + ped_pkg::ext_t'(pi_q);

	// table entry 0 marks a prime: the value is its own smallest factor
	assign pa_eff = (a_q == ped_pkg::val_t'(1)) ? ped_pkg::P_NONE :
		(raw_a_q == '0) ? ped_pkg::ext_t'(a_q) : ped_pkg::ext_t'(raw_a_q);
	assign pb_eff = (b_q == ped_pkg::val_t'(1)) ? ped_pkg::P_NONE :
		(raw_b_q == '0) ? ped_pkg::ext_t'(b_q) : ped_pkg::ext_t'(raw_b_q);
	assign take_a    = (pa_eff <= pb_eff);
	assign p_sel     = take_a ? pa_eff : pb_eff;
	assign raw_sel   = take_a ? raw_a_q : raw_b_q;
	assign both_done = (pa_eff == ped_pkg::P_NONE) && (pb_eff == ped_pkg::P_NONE);

	assign mag      = diff_q[ped_pkg::DIFF_W-1] ? -diff_q : diff_q;
	assign dist_tot = dist_q + ped_pkg::acc_t'(mag);

	assign load_rsp = (state_q == ped_pkg::ST_FIN) && (!rsp_vld_q || rsp.ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ped_pkg::ST_INIT: begin
				if (cnt_q == ped_pkg::ext_t'(ped_pkg::VALUE_LIMIT - 1)) state_d = ped_pkg::ST_SV_NEXT;
			end
			ped_pkg::ST_SV_NEXT: begin
				if (pi_q < ped_pkg::spf_t'(2)) state_d = ped_pkg::ST_IDLE;
				else if (ped_pkg::PRIME_MASK[pi_q]) state_d = ped_pkg::ST_SV_SQ;
			end
			ped_pkg::ST_SV_SQ:   state_d = ped_pkg::ST_SV_MARK;
			ped_pkg::ST_SV_MARK: begin
				if (j_next >= ped_pkg::ext_t'(ped_pkg::VALUE_LIMIT)) state_d = ped_pkg::ST_SV_NEXT;
			end
			ped_pkg::ST_IDLE: begin
				if (req.valid) state_d = accept_err ? ped_pkg::ST_FIN : ped_pkg::ST_LD_A;
			end
			ped_pkg::ST_LD_A:    state_d = ped_pkg::ST_LD_B;
			ped_pkg::ST_LD_B:    state_d = ped_pkg::ST_LD_WAIT;
			ped_pkg::ST_LD_WAIT: state_d = ped_pkg::ST_STEP;
			ped_pkg::ST_STEP:    state_d = both_done ? ped_pkg::ST_FIN : ped_pkg::ST_MUL;
			ped_pkg::ST_MUL:     state_d = ped_pkg::ST_RD;
			ped_pkg::ST_RD:      state_d = ped_pkg::ST_RD_WAIT;
			ped_pkg::ST_RD_WAIT: state_d = ped_pkg::ST_STEP;
			ped_pkg::ST_FIN: begin
				if (!rsp_vld_q || rsp.ready) state_d = ped_pkg::ST_IDLE;
			end
			default:             state_d = ped_pkg::ST_INIT;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cnt_q[ped_pkg::VAL_W-1:0];
		mem_wdata = '0;
		mem_raddr = a_q;
		unique case (state_q)
			ped_pkg::ST_INIT:    mem_we = 1'b1;
			ped_pkg::ST_SV_MARK: begin
				mem_we    = 1'b1;
				mem_wdata = pi_q;
			end
			ped_pkg::ST_IDLE:    req.ready = 1'b1;
			ped_pkg::ST_LD_A:    mem_raddr = a_q;
			ped_pkg::ST_LD_B:    mem_raddr = b_q;
			ped_pkg::ST_RD:      mem_raddr = side_q ? a_q : b_q;
			default:             mem_raddr = a_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ped_pkg::ST_INIT;
			cnt_q     <= '0;
			pi_q      <= ped_pkg::spf_t'(ped_pkg::ROOT_CNT - 1);
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ped_pkg::ST_INIT:    cnt_q <= cnt_q + ped_pkg::ext_t'(1);
				ped_pkg::ST_SV_NEXT: begin
					if (!(pi_q < ped_pkg::spf_t'(2)) && !ped_pkg::PRIME_MASK[pi_q]) begin
						pi_q <= pi_q - ped_pkg::spf_t'(1);
					end
				end
				ped_pkg::ST_SV_SQ:   cnt_q <= product[ped_pkg::VAL_W:0];
				ped_pkg::ST_SV_MARK: begin
					cnt_q <= j_next;
					if (j_next >= ped_pkg::ext_t'(ped_pkg::VALUE_LIMIT)) begin
						pi_q <= pi_q - ped_pkg::spf_t'(1);
					end
				end
				default: ;
			endcase
			if (load_rsp) rsp_vld_q <= 1'b1;
			else if (rsp.ready) rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ped_pkg::ST_SV_NEXT: begin
				mul_a_q <= ped_pkg::val_t'(pi_q);
				mul_b_q <= ped_pkg::val_t'(pi_q);
			end
			ped_pkg::ST_IDLE: begin
				if (accept) begin
					a_q      <= ped_pkg::val_t'(req.first_value);
					b_q      <= ped_pkg::val_t'(req.second_value);
					err_q    <= accept_err;
					diff_q   <= '0;
					dist_q   <= '0;
					cnt_a_q  <= '0;
					cur_q    <= '0;
					last_a_q <= '0;
				end
			end
			ped_pkg::ST_LD_B:    raw_a_q <= rd_q;
			ped_pkg::ST_LD_WAIT: raw_b_q <= rd_q;
			ped_pkg::ST_STEP: begin
				if (!both_done) begin
					mul_a_q <= take_a ? a_q : b_q;
					mul_b_q <= ped_pkg::RECIP[raw_sel];
					prime_q <= (raw_sel == '0);
					side_q  <= take_a;
					// a new prime closes the running exponent difference of the last one
					if (ped_pkg::val_t'(p_sel) != cur_q) begin
						dist_q <= dist_tot;
						diff_q <= take_a ? ped_pkg::diff_t'(1) : ped_pkg::diff_t'(-1);
					end else begin
						diff_q <= take_a ? diff_q + ped_pkg::diff_t'(1) : diff_q - ped_pkg::diff_t'(1);
					end
					cur_q <= ped_pkg::val_t'(p_sel);
					if (take_a && (ped_pkg::val_t'(p_sel) != last_a_q)) begin
						last_a_q <= ped_pkg::val_t'(p_sel);
						if (cnt_a_q != '1) cnt_a_q <= cnt_a_q + ped_pkg::cnt_t'(1);
					end
				end
			end
			ped_pkg::ST_MUL: begin
				if (side_q) a_q <= quot;
				else b_q <= quot;
			end
			ped_pkg::ST_RD_WAIT: begin
				if (side_q) raw_a_q <= rd_q;
				else raw_b_q <= rd_q;
			end
			default: ;
		endcase
		if (load_rsp) begin
			out_err_q <= err_q;
			out_cnt_q <= err_q ? '0 : cnt_a_q;
			if (err_q) out_dist_q <= '0;
			else if (dist_tot > ped_pkg::DIST_MAX) out_dist_q <= '1;
			else out_dist_q <= dist_tot[ped_pkg::DIST_W-1:0];
		end
	end

	assign rsp.valid                 = rsp_vld_q;
	assign rsp.distinct_primes_first = out_cnt_q;
	assign rsp.exponent_distance     = out_dist_q;
	assign rsp.input_error           = out_err_q;

endmodule

// File: hdl/ped_checker.sv
// ped_checker: port-level checks on the prime exponent distance block, bound to the top.
// Depends on ped_pkg and prime_exponent_distance.
module ped_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [ped_pkg::CNT_W-1:0]   distinct_primes_first,
	input logic [ped_pkg::DIST_W-1:0]  exponent_distance,
	input logic                        input_error
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(distinct_primes_first) &&
			$stable(exponent_distance) && $stable(input_error))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && input_error |-> distinct_primes_first == '0 && exponent_distance == '0)
		else $error("rejected request with non-zero fields");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in progress");

endmodule

bind prime_exponent_distance ped_checker u_ped_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.req_valid             (req.valid),
	.req_ready             (req.ready),
	.rsp_valid             (rsp.valid),
	.rsp_ready             (rsp.ready),
	.distinct_primes_first (rsp.distinct_primes_first),
	.exponent_distance     (rsp.exponent_distance),
	.input_error           (rsp.input_error)
);
